// ===== hw/rtl/mpq_pkg.sv =====
// Package for the multilevel priority ready queue.
// Holds the default sizes, the operation codes and the sequencer state type.
// Depends on nothing.
package mpq_pkg;

    localparam int MAX_LEVELS_DEF  = 8;
    localparam int LEVEL_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    localparam logic [3:0] LEVELS_RESET = 4'd4;

    localparam logic       OP_ADD      = 1'b0;
    localparam logic       OP_DISPATCH = 1'b1;

    localparam logic [3:0] DYN_EXHAUSTED = 4'b1111;

    localparam logic       REG_LEVELS_IN_USE = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } mpq_state_t;

endpackage

// ===== hw/rtl/mpq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the task id store of the ready queue. Depends on nothing.
module mpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/multilevel_priority_ready_queue.sv =====
// Top level of the multilevel priority ready queue with active and expired banks.
// Uses mpq_pkg for types and constants and mpq_ram for the task id store.
//
// An item is taken when start is high and busy is low; busy then stays high until
// the result is out. An add gives its result strobe (done) after its execute step,
// a dispatch after its execute and read steps, because the dispatch waits for
// the registered read of the task id memory. One pointer and count update path and
// one memory access serve every item. The done strobe lasts one cycle and cannot be
// held off; a new item may be started in that same cycle.
module multilevel_priority_ready_queue #(
    parameter int MAX_LEVELS  = mpq_pkg::MAX_LEVELS_DEF,
    parameter int LEVEL_DEPTH = mpq_pkg::LEVEL_DEPTH_DEF,
    parameter int ID_BITS     = mpq_pkg::ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [7:0]  task_id,
    input  logic [3:0]  static_prio,
    input  logic signed [3:0] dyn_prio,
    output logic        done,
    output logic        grant_valid,
    output logic [7:0]  grant_id,
    output logic [2:0]  grant_level,
    output logic [2:0]  placed_level,
    output logic        placed_expired,
    output logic        rejected,
    output logic        banks_swapped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NQ    = 2 * MAX_LEVELS;
    localparam int QW    = $clog2(NQ);
    localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PW    = $clog2(LEVEL_DEPTH);
    localparam int CW    = $clog2(LEVEL_DEPTH + 1);
    localparam int DEPTH = NQ * LEVEL_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    mpq_pkg::mpq_state_t state_reg, state_next;

    logic              op_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [3:0]        sp_reg;
    logic [3:0]        dyn_reg;
    logic [3:0]        levels_reg;
    logic              bank_reg;
    logic [PW-1:0]     head_reg  [NQ];
    logic [PW-1:0]     tail_reg  [NQ];
    logic [CW-1:0]     count_reg [NQ];

    logic              done_reg;
    logic              grant_valid_reg;
    logic [7:0]        grant_id_reg;
    logic [2:0]        grant_level_reg;
    logic [2:0]        placed_level_reg;
    logic              placed_expired_reg;
    logic              rejected_reg;
    logic              swapped_reg;

    logic              accept;
    logic              cfg_write;
    logic [4:0]        eff5;

    logic              exhausted;
    logic [4:0]        add_lvl5;
    logic              add_bad;
    logic              add_bank;
    logic [QW-1:0]     add_q;

    logic [MAX_LEVELS-1:0] act_ne;
    logic [MAX_LEVELS-1:0] exp_ne;
    logic [LVL_W-1:0]  act_top;
    logic [LVL_W-1:0]  exp_top;
    logic              act_any;
    logic              exp_any;
    logic              swap;
    logic              disp_bank;
    logic [LVL_W-1:0]  disp_lvl;
    logic [4:0]        disp_lvl5;
    logic [QW-1:0]     disp_q;

    logic [QW-1:0]     sel_q;
    logic [CW-1:0]     sel_count;
    logic [PW-1:0]     sel_ptr;
    logic [PW-1:0]     sel_ptr_inc;
    logic              add_ok;
    logic              disp_ok;
    logic [AW-1:0]     mem_addr;
    logic [ID_BITS-1:0] mem_rdata;
    logic              mem_we;
    logic              mem_re;

    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == mpq_pkg::REG_LEVELS_IN_USE) ? {28'd0, levels_reg} : 32'd0;

    assign eff5 = ({1'b0, levels_reg} > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : {1'b0, levels_reg};

    // Add path: level and bank of the new task.
    assign exhausted = (dyn_reg == mpq_pkg::DYN_EXHAUSTED);
    assign add_lvl5  = exhausted ? ({1'b0, sp_reg} - 5'd1) : {1'b0, dyn_reg};
    assign add_bad   = (exhausted ? (sp_reg == 4'd0) : dyn_reg[3]) || (add_lvl5 >= eff5);
    assign add_bank  = bank_reg ^ exhausted;
    assign add_q     = QW'(add_lvl5[LVL_W-1:0]) + (add_bank ? QW'(MAX_LEVELS) : QW'(0));

    // Dispatch path: highest non-empty level in each bank.
    always_comb
    begin
        act_top = '0;
        exp_top = '0;
        for (int l = 0; l < MAX_LEVELS; l++)
        begin
            act_ne[l] = (count_reg[QW'(l) + (bank_reg ? QW'(MAX_LEVELS) : QW'(0))] != '0)
                        && (5'(l) < eff5);
            exp_ne[l] = (count_reg[QW'(l) + (bank_reg ? QW'(0) : QW'(MAX_LEVELS))] != '0)
                        && (5'(l) < eff5);
            if (act_ne[l])
            begin
                act_top = LVL_W'(l);
            end
            if (exp_ne[l])
            begin
                exp_top = LVL_W'(l);
            end
        end
    end

    assign act_any   = |act_ne;
    assign exp_any   = |exp_ne;
    assign swap      = !act_any && exp_any;
    assign disp_bank = bank_reg ^ swap;
    assign disp_lvl  = swap ? exp_top : act_top;
    assign disp_lvl5 = 5'(disp_lvl);
    assign disp_q    = QW'(disp_lvl) + (disp_bank ? QW'(MAX_LEVELS) : QW'(0));

    // Shared pointer and count unit: one queue entry per item.
    assign sel_q       = (op_reg == mpq_pkg::OP_DISPATCH) ? disp_q : add_q;
    assign sel_count   = count_reg[sel_q];
    assign sel_ptr     = (op_reg == mpq_pkg::OP_DISPATCH) ? head_reg[sel_q] : tail_reg[sel_q];
    assign sel_ptr_inc = (sel_ptr == PW'(LEVEL_DEPTH - 1)) ? '0 : sel_ptr + PW'(1);
    assign add_ok      = !add_bad && (sel_count < CW'(LEVEL_DEPTH));
    assign disp_ok     = act_any || exp_any;
    assign mem_addr    = AW'(sel_q) * AW'(LEVEL_DEPTH) + AW'(sel_ptr);
    assign mem_we      = (state_reg == mpq_pkg::ST_EXEC) && (op_reg == mpq_pkg::OP_ADD) && add_ok;
    assign mem_re      = (state_reg == mpq_pkg::ST_EXEC) && (op_reg == mpq_pkg::OP_DISPATCH)
                         && disp_ok;

    mpq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (id_reg),
        .re    (mem_re),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b1;
        unique case (state_reg)
            mpq_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = mpq_pkg::ST_EXEC;
                end
            end
            mpq_pkg::ST_EXEC:
            begin
                state_next = (op_reg == mpq_pkg::OP_DISPATCH) ? mpq_pkg::ST_READ
                                                              : mpq_pkg::ST_IDLE;
            end
            mpq_pkg::ST_READ:
            begin
                state_next = mpq_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mpq_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state: configuration, bank select, queue pointers and the strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= mpq_pkg::LEVELS_RESET;
            bank_reg   <= 1'b0;
            done_reg   <= 1'b0;
            for (int i = 0; i < NQ; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write && (paddr[2] == mpq_pkg::REG_LEVELS_IN_USE))
            begin
                levels_reg <= pwdata[3:0];
            end
            done_reg <= ((state_reg == mpq_pkg::ST_EXEC) && (op_reg == mpq_pkg::OP_ADD))
                        || (state_reg == mpq_pkg::ST_READ);
            if (mem_we)
            begin
                tail_reg[sel_q]  <= sel_ptr_inc;
                count_reg[sel_q] <= sel_count + CW'(1);
            end
            if (mem_re)
            begin
                head_reg[sel_q]  <= sel_ptr_inc;
                count_reg[sel_q] <= sel_count - CW'(1);
                bank_reg         <= disp_bank;
            end
        end
    end

    // Item capture and result fields.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op;
            id_reg  <= ID_BITS'(task_id);
            sp_reg  <= static_prio;
            dyn_reg <= dyn_prio;
        end
        if (state_reg == mpq_pkg::ST_EXEC)
        begin
            if (op_reg == mpq_pkg::OP_ADD)
            begin
                grant_valid_reg    <= 1'b0;
                grant_id_reg       <= 8'd0;
                grant_level_reg    <= 3'd0;
                placed_level_reg   <= add_ok ? add_lvl5[2:0] : 3'd0;
                placed_expired_reg <= add_ok && exhausted;
                rejected_reg       <= !add_ok;
                swapped_reg        <= 1'b0;
            end
            else
            begin
                grant_valid_reg    <= disp_ok;
                grant_level_reg    <= disp_ok ? disp_lvl5[2:0] : 3'd0;
                placed_level_reg   <= 3'd0;
                placed_expired_reg <= 1'b0;
                rejected_reg       <= 1'b0;
                swapped_reg        <= swap;
            end
        end
        if (state_reg == mpq_pkg::ST_READ)
        begin
            grant_id_reg <= grant_valid_reg ? 8'(mem_rdata) : 8'd0;
        end
    end

    assign done           = done_reg;
    assign grant_valid    = grant_valid_reg;
    assign grant_id       = grant_id_reg;
    assign grant_level    = grant_level_reg;
    assign placed_level   = placed_level_reg;
    assign placed_expired = placed_expired_reg;
    assign rejected       = rejected_reg;
    assign banks_swapped  = swapped_reg;

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mpq_pkg::ST_EXEC))
        else $error("accepted item did not enter the execute step");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == mpq_pkg::ST_EXEC) || ($past(state_reg) == mpq_pkg::ST_READ))
        else $error("result strobe without a preceding execute or read step");

    a_grant_not_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && grant_valid) |-> (!rejected && !placed_expired))
        else $error("grant and add status reported together");

    a_swap_flips_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (done && banks_swapped) |-> ($past(bank_reg, 2) != $past(bank_reg)))
        else $error("bank swap reported without a bank change");

    a_busy_till_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpq_pkg::ST_READ) |-> (busy && !done))
        else $error("queue idle while a dispatch read is pending");
`endif

endmodule
